/* src/chrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrs_pkg: shared types and constants
// Operation codes, status codes and beat structs of the relation store.
// ----------------------------------------------------------------------------
package chrs_pkg;
	localparam int NumBucketsDef  = 128;
	localparam int PoolEntriesDef = 1024;
	localparam logic [7:0] BucketCountReset = 8'd100;

	localparam logic [2:0] OP_INSERT     = 3'd0;
	localparam logic [2:0] OP_REMOVE     = 3'd1;
	localparam logic [2:0] OP_HAS_KEY    = 3'd2;
	localparam logic [2:0] OP_HAS_PAIR   = 3'd3;
	localparam logic [2:0] OP_COUNT_KEY  = 3'd4;
	localparam logic [2:0] OP_GET        = 3'd5;
	localparam logic [2:0] OP_COUNT_DATA = 3'd6;

	localparam logic [1:0] ST_MISS = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] key;
		logic signed [31:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic [10:0]        match_count;
		logic [10:0]        element_count;
	} rsp_t;
endpackage

/* src/chrs_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrs_mod: iterative key modulo unit
// Restoring division of a 32-bit key by the bucket count, one bit a cycle.
// ----------------------------------------------------------------------------
module chrs_mod #(
	parameter int BW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [31:0]   dividend,
	input  logic [BW:0]   divisor,
	output logic          done,
	output logic [BW-1:0] remainder
);
	logic [31:0] quo_q;
	logic [BW:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [BW+1:0] trial;

	assign trial = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= (BW+1)'(trial - {1'b0, divisor});
			else
				rem_q <= trial[BW:0];
		end
	end

	assign remainder = rem_q[BW-1:0];
endmodule

/* src/chained_hash_relation_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_relation_store: hash store of distinct (key, data) pairs
// Bucket chains in insertion order over a pooled node memory.
// ----------------------------------------------------------------------------
// Usage: raise start with a command beat while busy is low; busy rises in
// the next cycle and stays high until the result. The result beat shows on
// rsp for one cycle with done high; the receiver cannot stall it.
// bucket_count is written through cfg_we/cfg_data; the user must write it
// only while idle, since the block itself does not enforce this.
// Sequence: bit-serial modulo (one quotient bit a cycle), then a node
// memory read and a compare per chain node visited, then the list update.
// Count data sweeps the whole pool, a read and a compare per entry. Chain
// walks are capped at POOL_ENTRIES nodes. Reset: after arst_n releases, a
// clearing pass empties the bucket heads and tails while a second pass
// builds the free list and clears the live flags; both run together and
// busy stays high until both have finished.
// ----------------------------------------------------------------------------
module chained_hash_relation_store #(
	parameter int NUM_BUCKETS  = chrs_pkg::NumBucketsDef,
	parameter int POOL_ENTRIES = chrs_pkg::PoolEntriesDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  chrs_pkg::cmd_t cmd,
	output logic           done,
	output chrs_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data
);
	import chrs_pkg::*;

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int PW = $clog2(POOL_ENTRIES);
	localparam int NW = PW + 1;
	localparam logic [NW-1:0] NIL = NW'(POOL_ENTRIES);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_UPD   = 4'd6;
	localparam logic [3:0] S_INS   = 4'd7;
	localparam logic [3:0] S_SCAN  = 4'd8;
	localparam logic [3:0] S_SCMP  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_FREE  = 4'd11;

	logic [3:0]    state_q;
	logic [7:0]    bcnt_q;
	cmd_t          cmd_q;
	logic [BW-1:0] bkt_q;
	logic [NW-1:0] cur_q, prev_q, tail_q;
	logic [NW:0]   steps_q;
	logic [NW-1:0] cnt_q, live_q, ftop_q;
	logic [1:0]    stat_q;
	logic [31:0]   dout_q;
	logic [NW-1:0] init_q;

	logic [31:0]   mem_key [POOL_ENTRIES];
	logic [31:0]   mem_data[POOL_ENTRIES];
	logic [NW-1:0] mem_next[POOL_ENTRIES];
	logic          mem_live[POOL_ENTRIES];
	logic [PW-1:0] mem_free[POOL_ENTRIES];
	logic [NW-1:0] mem_head[NUM_BUCKETS];
	logic [NW-1:0] mem_tail[NUM_BUCKETS];

	logic [31:0]   rk_q, rd_q;
	logic [NW-1:0] rn_q;
	logic          rl_q;
	logic [PW-1:0] rf_q;
	logic [NW-1:0] rh_q, rt_q;

	logic [BW:0]   div;
	logic          mod_go, mod_done;
	logic [BW-1:0] mod_rem;
	logic          key_eq, pair_eq;

	always_comb begin
		if (bcnt_q == 8'd0)
			div = (BW+1)'(1);
		else if (32'(bcnt_q) > NUM_BUCKETS)
			div = (BW+1)'(NUM_BUCKETS);
		else
			div = (BW+1)'(bcnt_q);
	end

	assign mod_go = (state_q == S_IDLE) && start;

	chrs_mod #(.BW(BW)) u_mod (
		.clk(clk), .arst_n(arst_n), .go(mod_go), .dividend(cmd.key),
		.divisor(div), .done(mod_done), .remainder(mod_rem)
	);

	assign key_eq  = rk_q == cmd_q.key;
	assign pair_eq = key_eq && (rd_q == cmd_q.data_in);

	// memory ports
	logic          we_node, we_next, we_live, we_free, we_bh, we_bt;
	logic [PW-1:0] a_node, a_next, a_live, a_free, a_rd, a_frd;
	logic [NW-1:0] d_next, d_bh, d_bt;
	logic          d_live;
	logic [PW-1:0] d_free;
	logic [BW-1:0] a_bkt;

	always_ff @(posedge clk) begin
		if (we_node) begin
			mem_key[a_node]  <= cmd_q.key;
			mem_data[a_node] <= cmd_q.data_in;
		end
		if (we_next) mem_next[a_next] <= d_next;
		if (we_live) mem_live[a_live] <= d_live;
		if (we_free) mem_free[a_free] <= d_free;
		if (we_bh) mem_head[a_bkt] <= d_bh;
		if (we_bt) mem_tail[a_bkt] <= d_bt;
		rk_q <= mem_key[a_rd];
		rd_q <= mem_data[a_rd];
		rn_q <= mem_next[a_rd];
		rl_q <= mem_live[a_rd];
		rf_q <= mem_free[a_frd];
		rh_q <= mem_head[a_bkt];
		rt_q <= mem_tail[a_bkt];
	end

	always_comb begin
		we_node = 1'b0; we_next = 1'b0; we_live = 1'b0; we_free = 1'b0;
		we_bh = 1'b0; we_bt = 1'b0;
		a_node = ftop_q[PW-1:0]; a_next = cur_q[PW-1:0];
		a_live = cur_q[PW-1:0]; a_free = ftop_q[PW-1:0];
		a_rd = cur_q[PW-1:0]; a_frd = PW'(ftop_q - NW'(1));
		d_next = NIL; d_bh = NIL; d_bt = NIL; d_live = 1'b0;
		d_free = cur_q[PW-1:0];
		a_bkt = bkt_q;
		unique case (state_q)
			S_INIT: begin
				a_bkt = init_q[BW-1:0];
				we_bh = NW'(init_q) < NW'(NUM_BUCKETS);
				we_bt = we_bh;
				we_free = init_q < NW'(POOL_ENTRIES);
				we_live = we_free;
				a_free = init_q[PW-1:0];
				a_live = init_q[PW-1:0];
				d_free = PW'(NW'(POOL_ENTRIES - 1) - init_q);
			end
			S_MOD: a_bkt = mod_rem;
			S_UPD: begin
				if (cmd_q.operation == OP_REMOVE && cur_q != NIL) begin
					if (prev_q == NIL) begin
						we_bh = 1'b1; d_bh = rn_q;
					end else begin
						we_next = 1'b1; a_next = prev_q[PW-1:0]; d_next = rn_q;
					end
					if (tail_q == cur_q) begin
						we_bt = 1'b1; d_bt = prev_q;
					end
					we_live = 1'b1;
					we_free = ftop_q < NIL;
				end
			end
			S_INS: begin
				we_node = 1'b1; a_node = rf_q;
				we_next = 1'b1; a_next = rf_q; d_next = NIL;
				we_live = 1'b1; a_live = rf_q; d_live = 1'b1;
				we_bt = 1'b1; d_bt = {1'b0, rf_q};
				if (tail_q != NIL) begin
					we_free = 1'b0;
				end else begin
					we_bh = 1'b1; d_bh = {1'b0, rf_q};
				end
			end
			S_FREE: begin
				we_next = 1'b1; a_next = tail_q[PW-1:0]; d_next = {1'b0, rf_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			bcnt_q  <= BucketCountReset;
			init_q  <= '0;
			live_q  <= '0;
			ftop_q  <= NIL;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) bcnt_q <= cfg_data;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + NW'(1);
					if (init_q == NW'(POOL_ENTRIES - 1) &&
					    (POOL_ENTRIES >= NUM_BUCKETS))
						state_q <= S_IDLE;
					else if (init_q >= NW'(POOL_ENTRIES - 1) &&
					         init_q >= NW'(NUM_BUCKETS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (start) state_q <= S_MOD;
				S_MOD: if (mod_done) begin
					state_q <= (cmd_q.operation == OP_COUNT_DATA) ? S_SCAN :
					           (cmd_q.operation > OP_COUNT_DATA) ? S_DONE : S_HEAD;
				end
				S_HEAD: state_q <= S_RD;
				S_RD: state_q <= (cur_q == NIL || steps_q >= (NW+1)'(POOL_ENTRIES))
				                 ? S_UPD : S_CMP;
				S_CMP: begin
					if (cmd_q.operation == OP_INSERT || cmd_q.operation == OP_REMOVE ||
					    cmd_q.operation == OP_HAS_PAIR) begin
						state_q <= pair_eq ? S_UPD : S_RD;
					end else if (cmd_q.operation == OP_COUNT_KEY) begin
						state_q <= S_RD;
					end else begin
						state_q <= key_eq ? S_DONE : S_RD;
					end
				end
				S_UPD: begin
					if (cmd_q.operation == OP_REMOVE && cur_q != NIL) begin
						if (ftop_q < NIL) ftop_q <= ftop_q + NW'(1);
						if (live_q != '0) live_q <= live_q - NW'(1);
						state_q <= S_DONE;
					end else if (cmd_q.operation == OP_INSERT && cur_q == NIL &&
					             ftop_q != '0) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_INS: begin
					ftop_q <= ftop_q - NW'(1);
					live_q <= live_q + NW'(1);
					state_q <= (tail_q != NIL) ? S_FREE : S_DONE;
				end
				S_FREE: state_q <= S_DONE;
				S_SCAN: state_q <= (cur_q == NIL) ? S_DONE : S_SCMP;
				S_SCMP: state_q <= S_SCAN;
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				cnt_q <= '0;
				stat_q <= ST_MISS;
				dout_q <= '0;
			end
			S_MOD: begin
				bkt_q <= mod_rem;
				prev_q <= NIL;
				steps_q <= '0;
				cur_q <= '0;
			end
			S_HEAD: begin
				cur_q <= rh_q;
				tail_q <= rt_q;
			end
			S_CMP: begin
				if (cmd_q.operation == OP_INSERT || cmd_q.operation == OP_REMOVE ||
				    cmd_q.operation == OP_HAS_PAIR) begin
					if (!pair_eq) begin
						prev_q <= cur_q; cur_q <= rn_q; steps_q <= steps_q + 1'b1;
					end
				end else begin
					if (key_eq) begin
						if (cmd_q.operation == OP_COUNT_KEY) begin
							cnt_q <= cnt_q + NW'(1);
							stat_q <= ST_OK;
						end else begin
							stat_q <= ST_OK;
							if (cmd_q.operation == OP_GET) dout_q <= rd_q;
						end
					end
					cur_q <= rn_q; steps_q <= steps_q + 1'b1;
				end
			end
			S_RD: begin
				if (cur_q == NIL || steps_q >= (NW+1)'(POOL_ENTRIES)) cur_q <= NIL;
			end
			S_UPD: begin
				if (cmd_q.operation == OP_HAS_PAIR)
					stat_q <= (cur_q != NIL) ? ST_OK : ST_MISS;
				else if (cmd_q.operation == OP_REMOVE)
					stat_q <= (cur_q != NIL) ? ST_OK : ST_MISS;
				else if (cmd_q.operation == OP_INSERT) begin
					if (cur_q != NIL)
						stat_q <= ST_MISS;
					else if (ftop_q == '0)
						stat_q <= ST_FULL;
					else
						stat_q <= ST_OK;
				end
			end
			S_SCAN: ;
			S_SCMP: begin
				if (rl_q && rd_q == cmd_q.data_in) begin
					cnt_q <= cnt_q + NW'(1);
					stat_q <= ST_OK;
				end
				cur_q <= (cur_q == NW'(POOL_ENTRIES - 1)) ? NIL : cur_q + NW'(1);
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	always_comb begin
		rsp.status        = stat_q;
		rsp.data_out      = dout_q;
		rsp.match_count   = 11'(cnt_q);
		rsp.element_count = 11'(live_q);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("stray result");
	assert property (@(posedge clk) disable iff (!arst_n)
		live_q + ftop_q == NW'(POOL_ENTRIES) || state_q == S_INS)
		else $error("pool accounting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
endmodule

/* verif/chained_hash_relation_store_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_relation_store_checker: result predictor and scoreboard
// Watches the command, result and config channels. Keeps its own copy of
// the store, works out the result of every accepted command and compares
// each result beat field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module chained_hash_relation_store_checker
	import chrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  cmd_t       cmd,
	input  logic       done,
	input  rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output int         pending,
	output int         failures
);
	localparam int NBKT = NumBucketsDef;
	localparam int POOL = PoolEntriesDef;
	localparam int NIL  = POOL;

	logic [7:0]  bkt_count;
	int          head_of[NBKT];
	int          tail_of[NBKT];
	logic [31:0] node_key[POOL];
	logic [31:0] node_data[POOL];
	int          node_next[POOL];
	bit          node_live[POOL];
	int          free_stack[POOL];
	int          free_top;
	int          live_total;
	rsp_t        rsp_expected_q[$];

	task automatic clear_store();
		bkt_count = BucketCountReset;
		for (int i = 0; i < NBKT; i++) begin
			head_of[i] = NIL;
			tail_of[i] = NIL;
		end
		for (int i = 0; i < POOL; i++) begin
			node_key[i]   = '0;
			node_data[i]  = '0;
			node_next[i]  = NIL;
			node_live[i]  = 1'b0;
			free_stack[i] = POOL - 1 - i;
		end
		free_top   = POOL;
		live_total = 0;
	endtask

	task automatic apply_command(input cmd_t c, output rsp_t r);
		logic [31:0] k, d;
		int          n, b, cur, prev, steps, cnt, nx, t;
		logic [1:0]  st;
		logic [31:0] dout;
		k    = c.key;
		d    = c.data_in;
		n    = (bkt_count == 0) ? 1 : ((bkt_count > NBKT) ? NBKT : bkt_count);
		b    = k % n;
		st   = ST_MISS;
		dout = '0;
		cnt  = 0;
		case (c.operation)
			OP_INSERT, OP_REMOVE, OP_HAS_PAIR: begin
				prev  = NIL;
				cur   = head_of[b];
				steps = 0;
				while (cur < NIL && steps < POOL) begin
					if (node_key[cur] == k && node_data[cur] == d)
						break;
					prev = cur;
					cur  = node_next[cur];
					steps++;
				end
				if (cur >= NIL || steps >= POOL)
					cur = NIL;
				if (c.operation == OP_HAS_PAIR) begin
					st = (cur != NIL) ? ST_OK : ST_MISS;
				end else if (c.operation == OP_REMOVE) begin
					if (cur != NIL) begin
						nx = node_next[cur];
						if (prev == NIL)
							head_of[b] = nx;
						else
							node_next[prev] = nx;
						if (tail_of[b] == cur)
							tail_of[b] = prev;
						node_live[cur] = 1'b0;
						node_next[cur] = NIL;
						if (free_top < POOL)
							free_stack[free_top++] = cur;
						if (live_total > 0)
							live_total--;
						st = ST_OK;
					end
				end else if (cur != NIL) begin
					st = ST_MISS;
				end else if (free_top == 0) begin
					st = ST_FULL;
				end else begin
					nx = free_stack[--free_top];
					t  = tail_of[b];
					node_key[nx]  = k;
					node_data[nx] = d;
					node_next[nx] = NIL;
					node_live[nx] = 1'b1;
					if (t < NIL)
						node_next[t] = nx;
					else
						head_of[b] = nx;
					tail_of[b] = nx;
					live_total++;
					st = ST_OK;
				end
			end
			OP_HAS_KEY, OP_COUNT_KEY, OP_GET: begin
				cur   = head_of[b];
				steps = 0;
				while (cur < NIL && steps < POOL) begin
					if (node_key[cur] == k) begin
						if (c.operation == OP_COUNT_KEY) begin
							cnt++;
						end else begin
							st = ST_OK;
							if (c.operation == OP_GET)
								dout = node_data[cur];
							break;
						end
					end
					cur = node_next[cur];
					steps++;
				end
				if (c.operation == OP_COUNT_KEY)
					st = (cnt != 0) ? ST_OK : ST_MISS;
			end
			OP_COUNT_DATA: begin
				for (int i = 0; i < POOL; i++)
					if (node_live[i] && node_data[i] == d)
						cnt++;
				st = (cnt != 0) ? ST_OK : ST_MISS;
			end
			default: ;
		endcase
		r.status        = st;
		r.data_out      = dout;
		r.match_count   = cnt[10:0];
		r.element_count = live_total[10:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_store();
			rsp_expected_q.delete();
			pending  <= 0;
			failures <= 0;
		end else begin
			if (done) begin
				if (rsp_expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %h", $time, rsp);
					failures <= failures + 1;
				end else begin
					want = rsp_expected_q.pop_front();
					if (rsp.status !== want.status || rsp.data_out !== want.data_out
						|| rsp.match_count !== want.match_count
						|| rsp.element_count !== want.element_count) begin
						$display("%0t: mismatch, expected st=%0d dout=%h cnt=%0d elems=%0d, actual st=%0d dout=%h cnt=%0d elems=%0d",
							$time, want.status, want.data_out, want.match_count,
							want.element_count, rsp.status, rsp.data_out,
							rsp.match_count, rsp.element_count);
						failures <= failures + 1;
					end
				end
			end
			if (start && !busy) begin
				apply_command(cmd, want);
				rsp_expected_q.push_back(want);
			end
			if (cfg_we)
				bkt_count = cfg_data;
			pending <= rsp_expected_q.size();
		end
	end
endmodule

/* verif/chained_hash_relation_store_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_relation_store_tb: stimulus and verdict
// Directed commands over every operation and field extreme, then random
// phases under several bucket counts, a pool fill to overflow and a partial drain,
// with random gaps between command beats. Checking lives in the checker.
// ----------------------------------------------------------------------------
module chained_hash_relation_store_tb;
	import chrs_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	cmd_t       cmd = '0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       busy, done;
	rsp_t       rsp;
	int         pending, failures;
	int         n_beats = 0;
	logic [31:0] fill_key[1100];
	logic [31:0] key_set[12] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		32'd100, 32'd128, 32'd7, 32'd64, 32'd227, 32'hDEAD_BEEF, 32'd99};
	logic [31:0] data_set[6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		32'd5, 32'h1234_5678};

	always #5 clk = ~clk;

	chained_hash_relation_store uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	chained_hash_relation_store_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.pending(pending), .failures(failures)
	);

	task automatic issue(input logic [2:0] op, input logic [31:0] k, input logic [31:0] d);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd   <= '{operation: op, key: k, data_in: d};
		start <= 1'b1;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		n_beats++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
	endtask

	task automatic set_buckets(input logic [7:0] v);
		settle();
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		return ($urandom_range(0, 9) < 6) ? key_set[$urandom_range(0, 11)] : $urandom;
	endfunction

	function automatic logic [31:0] pick_data();
		return ($urandom_range(0, 9) < 7) ? data_set[$urandom_range(0, 5)] : $urandom;
	endfunction

	task automatic random_mix(input int count);
		int         r;
		logic [2:0] op;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)      op = OP_INSERT;
			else if (r < 55) op = OP_REMOVE;
			else if (r < 65) op = OP_HAS_KEY;
			else if (r < 75) op = OP_HAS_PAIR;
			else if (r < 85) op = OP_COUNT_KEY;
			else if (r < 95) op = OP_GET;
			else if (r < 97) op = OP_COUNT_DATA;
			else             op = 3'd7;
			issue(op, pick_key(), pick_data());
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		settle();

		issue(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
		issue(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
		issue(OP_INSERT, 32'd100, 32'h0);
		issue(OP_INSERT, 32'h0, 32'h0);
		issue(OP_HAS_KEY, 32'h8000_0000, 32'h0);
		issue(OP_HAS_KEY, 32'd200, 32'h0);
		issue(OP_HAS_PAIR, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_HAS_PAIR, 32'h7FFF_FFFF, 32'h0);
		issue(OP_COUNT_KEY, 32'h8000_0000, 32'h0);
		issue(OP_COUNT_KEY, 32'd5, 32'h0);
		issue(OP_GET, 32'h8000_0000, 32'h0);
		issue(OP_GET, 32'd5, 32'h0);
		issue(OP_COUNT_DATA, 32'h0, 32'h0);
		issue(OP_COUNT_DATA, 32'h0, 32'h1234_5678);
		issue(OP_REMOVE, 32'd5, 32'd5);
		issue(OP_REMOVE, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(OP_GET, 32'h8000_0000, 32'h0);
		issue(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		set_buckets(8'd0);
		random_mix(100);
		set_buckets(8'd1);
		random_mix(50);
		set_buckets(8'd255);
		for (int i = 0; i < 1030; i++) begin
			fill_key[i] = $urandom;
			issue(OP_INSERT, fill_key[i], i);
		end
		issue(OP_INSERT, fill_key[0], 32'd0);
		issue(OP_COUNT_DATA, 32'h0, 32'd3);
		settle();
		for (int i = 0; i < 150; i++)
			issue(OP_REMOVE, fill_key[i], i);
		random_mix(75);
		set_buckets(8'd7);
		random_mix(75);
		set_buckets(8'd128);
		random_mix(75);

		settle();
		repeat (100) @(negedge clk);
		$display("Ran %0d command beats: all operations, key and data extremes,", n_beats);
		$display("bucket counts 100/0/1/255/7/128, pool fill to overflow and removals.");
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
